FILE: design/ubc_pkg.sv
`default_nettype none

package ubc_pkg;

    localparam int unsigned RingDepth  = 2048;
    localparam int unsigned MaxBlock   = 512;
    localparam int unsigned PacketSize = 64;

    localparam int unsigned AddrW = $clog2(RingDepth);
    localparam int unsigned LenW  = 10;
    localparam int unsigned PktW  = $clog2(PacketSize);

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    typedef enum logic [2:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_DROPPED  = 3'd1,
        KIND_NOT_DONE = 3'd2,
        KIND_STARTED  = 3'd3,
        KIND_ZLP      = 3'd4,
        KIND_EMPTY    = 3'd5,
        KIND_REFUSED  = 3'd6,
        KIND_PEEK     = 3'd7
    } t_kind;

    typedef struct packed {
        logic [AddrW-1:0] write_pos;
        logic [AddrW-1:0] read_pos;
        logic [LenW-1:0]  pending;
    } t_ring_state;

    typedef struct packed {
        t_kind            kind;
        logic [AddrW-1:0] start_index;
        logic [LenW-1:0]  chunk_length;
        logic [AddrW-1:0] free_bytes;
    } t_step_result;

    typedef struct packed {
        logic             en;
        logic [AddrW-1:0] addr;
        logic [7:0]       data;
    } t_store_wr;

endpackage

`default_nettype wire

FILE: design/ubc_step.sv
`default_nettype none

module ubc_step (
    input  wire logic [1:0]             i_opcode,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_tx_done,
    input  wire logic                   i_send_accepted,
    input  wire logic [9:0]             i_block_limit,
    input  wire ubc_pkg::t_ring_state   i_state,
    output ubc_pkg::t_ring_state        o_state,
    output ubc_pkg::t_step_result       o_result,
    output ubc_pkg::t_store_wr          o_wr
);
    import ubc_pkg::*;

    logic [AddrW-1:0] free_now;
    logic [AddrW-1:0] rp_ret;
    logic [AddrW:0]   span;
    logic [LenW-1:0]  limit;
    logic [LenW-1:0]  len;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_wr     = '0;
        o_wr.addr = i_state.write_pos;
        o_wr.data = i_data_byte;

        free_now = i_state.read_pos - i_state.write_pos - 1'b1;

        if (i_state.pending != '0) begin
            rp_ret = i_state.read_pos + {1'b0, i_state.pending};
        end else begin
            rp_ret = i_state.read_pos;
        end

        if (rp_ret > i_state.write_pos) begin
            span = (AddrW+1)'(RingDepth) - {1'b0, rp_ret};
        end else begin
            span = {1'b0, i_state.write_pos - rp_ret};
        end

        if (i_block_limit == '0) begin
            limit = LenW'(1);
        end else if (i_block_limit > LenW'(MaxBlock)) begin
            limit = LenW'(MaxBlock);
        end else begin
            limit = i_block_limit;
        end

        if (span > {1'b0, limit}) begin
            len = limit;
        end else begin
            len = span[LenW-1:0];
        end

        unique case (i_opcode)
            OP_PUSH: begin
                if (free_now == '0) begin
                    o_result.kind = KIND_DROPPED;
                end else begin
                    o_result.kind     = KIND_ACCEPTED;
                    o_wr.en           = 1'b1;
                    o_state.write_pos = i_state.write_pos + 1'b1;
                end
            end
            OP_TICK: begin
                if (!i_tx_done) begin
                    o_result.kind        = KIND_NOT_DONE;
                    o_result.start_index = i_state.read_pos;
                end else begin
                    o_state.read_pos     = rp_ret;
                    o_state.pending      = '0;
                    o_result.start_index = rp_ret;
                    if (i_state.pending != '0 && i_state.pending[PktW-1:0] == '0) begin
                        o_result.kind = KIND_ZLP;
                    end else if (rp_ret == i_state.write_pos) begin
                        o_result.kind = KIND_EMPTY;
                    end else begin
                        o_result.chunk_length = len;
                        if (i_send_accepted) begin
                            o_result.kind   = KIND_STARTED;
                            o_state.pending = len;
                        end else begin
                            o_result.kind = KIND_REFUSED;
                        end
                    end
                end
            end
            default: begin
                o_result.kind = KIND_PEEK;
            end
        endcase

        o_result.free_bytes = o_state.read_pos - o_state.write_pos - 1'b1;
    end

endmodule

`default_nettype wire

FILE: design/usb_bulk_in_tx_ring_chunker.sv
`default_nettype none
// Transmit ring for a bulk IN endpoint with a 2048-byte store.
// An item is taken on start while busy is low; busy never rises, so an item
// can be issued every cycle. The opcode selects a byte push, a polling tick
// or a peek of one stored byte for the endpoint's data fetch.
// Each item gives one result, shown for one cycle with o_valid high once the
// item has passed the input register and the result register.
// The receiver cannot stall and must take every result in the cycle it appears.
// The item passes through an input register, one short step of pointer
// logic and a result register. The store's read for a peek is issued at the
// accepting edge and a write from the item just ahead is forwarded.
// The block limit is written through its own channel, which is always ready; the user must
// write it only while no item is in flight, as the block itself does not enforce this.
// Reset clears both pointers, the pending chunk length and the pipeline
// valids, and sets the block limit to 512. Store contents are undefined
// until written.
module usb_bulk_in_tx_ring_chunker (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               i_opcode,
    input  wire logic [7:0]               i_data_byte,
    input  wire logic                     i_tx_done,
    input  wire logic                     i_send_accepted,
    input  wire logic [ubc_pkg::AddrW-1:0] i_peek_index,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [9:0]               i_cfg_data,
    output logic                          o_valid,
    output logic [2:0]                    o_kind,
    output logic [ubc_pkg::AddrW-1:0]     o_start_index,
    output logic [9:0]                    o_chunk_length,
    output logic [ubc_pkg::AddrW-1:0]     o_free_bytes,
    output logic [7:0]                    o_peek_byte
);
    import ubc_pkg::*;

    logic [7:0]       r_store [RingDepth];
    logic [7:0]       r_rd_data;
    logic             r_byp;
    logic [7:0]       r_byp_data;

    logic             r_in_valid;
    logic [1:0]       r_in_opcode;
    logic [7:0]       r_in_data_byte;
    logic             r_in_tx_done;
    logic             r_in_send_accepted;

    logic             r_out_valid;
    t_step_result     r_out;
    logic [7:0]       r_out_peek;

    t_ring_state      r_state;
    t_ring_state      n_state;
    logic [9:0]       r_block_limit;

    t_step_result     step_result;
    t_store_wr        step_wr;
    logic             wr_en;
    logic [7:0]       peek_data;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    ubc_step u_step (
        .i_opcode        (r_in_opcode),
        .i_data_byte     (r_in_data_byte),
        .i_tx_done       (r_in_tx_done),
        .i_send_accepted (r_in_send_accepted),
        .i_block_limit   (r_block_limit),
        .i_state         (r_state),
        .o_state         (n_state),
        .o_result        (step_result),
        .o_wr            (step_wr)
    );

    assign wr_en     = r_in_valid && step_wr.en;
    assign peek_data = r_byp ? r_byp_data : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[step_wr.addr] <= step_wr.data;
        end
        if (start && !busy) begin
            r_rd_data  <= r_store[i_peek_index];
            r_byp      <= wr_en && (step_wr.addr == i_peek_index);
            r_byp_data <= step_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= '0;
            r_block_limit <= 10'd512;
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_block_limit <= i_cfg_data;
            end
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in_opcode        <= i_opcode;
            r_in_data_byte     <= i_data_byte;
            r_in_tx_done       <= i_tx_done;
            r_in_send_accepted <= i_send_accepted;
        end
        if (r_in_valid) begin
            r_out <= step_result;
            if (step_result.kind == KIND_PEEK) begin
                r_out_peek <= peek_data;
            end else begin
                r_out_peek <= 8'd0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_start_index  = r_out.start_index;
    assign o_chunk_length = r_out.chunk_length;
    assign o_free_bytes   = r_out.free_bytes;
    assign o_peek_byte    = r_out_peek;

endmodule

`default_nettype wire

FILE: bench/tb_usb_bulk_in_tx_ring_chunker.sv
`default_nettype none

module tb_usb_bulk_in_tx_ring_chunker;

    import ubc_pkg::*;

    localparam logic [1:0] OP_PEEK_ALT = 2'd3;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        logic [1:0]       op;
        logic [7:0]       data;
        logic             done;
        logic             acc;
        logic [AddrW-1:0] pidx;
        bit               pick;
    } t_ring_op;

    typedef struct {
        t_kind            kind;
        logic [AddrW-1:0] start_index;
        logic [LenW-1:0]  chunk_length;
        logic [AddrW-1:0] free_bytes;
        logic [7:0]       peek_byte;
    } t_ring_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       i_opcode = OP_PUSH;
    logic [7:0]       i_data_byte = 8'd0;
    logic             i_tx_done = 1'b0;
    logic             i_send_accepted = 1'b0;
    logic [AddrW-1:0] i_peek_index = '0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [9:0]       i_cfg_data = 10'd0;
    logic             o_valid;
    logic [2:0]       o_kind;
    logic [AddrW-1:0] o_start_index;
    logic [9:0]       o_chunk_length;
    logic [AddrW-1:0] o_free_bytes;
    logic [7:0]       o_peek_byte;

    usb_bulk_in_tx_ring_chunker u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_data_byte     (i_data_byte),
        .i_tx_done       (i_tx_done),
        .i_send_accepted (i_send_accepted),
        .i_peek_index    (i_peek_index),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_start_index   (o_start_index),
        .o_chunk_length  (o_chunk_length),
        .o_free_bytes    (o_free_bytes),
        .o_peek_byte     (o_peek_byte)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the ring as the block should hold it.
    logic [7:0]       ring_mem [RingDepth];
    bit               ever_written [RingDepth];
    logic [AddrW-1:0] written_list [$];
    logic [AddrW-1:0] wr_ptr = '0;
    logic [AddrW-1:0] rd_ptr = '0;
    logic [LenW-1:0]  chunk_pending = '0;
    logic [9:0]       limit_reg = 10'd512;

    t_ring_op     ring_ops_pending [$];
    t_ring_result ring_results_due [$];
    int unsigned  queued_count = 0;
    int unsigned  accepted_count = 0;
    int unsigned  idle_pct = 0;
    int unsigned  error_count = 0;
    int unsigned  quiet_cycles = 0;
    bit           beat_taken = 1'b0;
    t_ring_result want;

    function automatic logic [AddrW-1:0] ring_free();
        logic [AddrW-1:0] f;
        f = rd_ptr - wr_ptr - 1'b1;
        return f;
    endfunction

    function automatic t_ring_result next_ring_result(input logic [1:0] op,
            input logic [7:0] data, input logic done, input logic acc,
            input logic [AddrW-1:0] pidx);
        t_ring_result     res;
        logic [LenW-1:0]  retired;
        int unsigned      span;
        int unsigned      cap;
        res.kind = KIND_PEEK;
        res.start_index = '0;
        res.chunk_length = '0;
        res.peek_byte = '0;
        if (op == OP_PUSH) begin
            if (ring_free() == 0) begin
                res.kind = KIND_DROPPED;
            end else begin
                res.kind = KIND_ACCEPTED;
                ring_mem[wr_ptr] = data;
                if (!ever_written[wr_ptr]) begin
                    ever_written[wr_ptr] = 1'b1;
                    written_list.push_back(wr_ptr);
                end
                wr_ptr = wr_ptr + 1'b1;
            end
        end else if (op == OP_TICK) begin
            if (!done) begin
                res.kind = KIND_NOT_DONE;
            end else begin
                retired = chunk_pending;
                rd_ptr = rd_ptr + retired;
                chunk_pending = '0;
                if (retired != 0 && retired % PacketSize == 0) begin
                    res.kind = KIND_ZLP;
                end else if (rd_ptr == wr_ptr) begin
                    res.kind = KIND_EMPTY;
                end else begin
                    span = (rd_ptr > wr_ptr) ? RingDepth - rd_ptr : wr_ptr - rd_ptr;
                    cap = (limit_reg == 0) ? 1 : (limit_reg > MaxBlock) ? MaxBlock : limit_reg;
                    if (span > cap) begin
                        span = cap;
                    end
                    res.chunk_length = span[LenW-1:0];
                    if (acc) begin
                        chunk_pending = span[LenW-1:0];
                        res.kind = KIND_STARTED;
                    end else begin
                        res.kind = KIND_REFUSED;
                    end
                end
            end
            res.start_index = rd_ptr;
        end else begin
            res.peek_byte = ring_mem[pidx];
        end
        res.free_bytes = ring_free();
        return res;
    endfunction

    // A peek marked for picking reads a stored entry chosen at drive time,
    // so that no entry that was never written gets read.
    always @(negedge i_clk) begin : feed_ops
        t_ring_op it;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !beat_taken) begin
            start <= 1'b1;
        end else if (ring_ops_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
            it = ring_ops_pending.pop_front();
            if (it.pick) begin
                if (written_list.size() == 0) begin
                    it.op = OP_TICK;
                    it.done = 1'b0;
                end else begin
                    it.pidx = written_list[$urandom_range(written_list.size() - 1)];
                end
            end
            start <= 1'b1;
            i_opcode <= it.op;
            i_data_byte <= it.data;
            i_tx_done <= it.done;
            i_send_accepted <= it.acc;
            i_peek_index <= it.pidx;
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : watch_results
        bit progress;
        if (!i_rst_n) begin
            beat_taken = 1'b0;
            quiet_cycles = 0;
        end else begin
            progress = 1'b0;
            if (o_valid) begin
                progress = 1'b1;
                if (ring_results_due.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("unexpected result: kind %0d start %0d len %0d free %0d byte %0h",
                                 o_kind, o_start_index, o_chunk_length, o_free_bytes,
                                 o_peek_byte);
                    end
                end else begin
                    want = ring_results_due.pop_front();
                    if (o_kind !== want.kind || o_start_index !== want.start_index
                            || o_chunk_length !== want.chunk_length
                            || o_free_bytes !== want.free_bytes
                            || o_peek_byte !== want.peek_byte) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display("mismatch: expected kind %0d start %0d len %0d free %0d byte %0h",
                                     want.kind, want.start_index, want.chunk_length,
                                     want.free_bytes, want.peek_byte);
                            $display("          actual   kind %0d start %0d len %0d free %0d byte %0h",
                                     o_kind, o_start_index, o_chunk_length, o_free_bytes,
                                     o_peek_byte);
                        end
                    end
                end
            end
            beat_taken = start && !busy;
            if (beat_taken) begin
                progress = 1'b1;
                accepted_count++;
                ring_results_due.push_back(next_ring_result(i_opcode, i_data_byte, i_tx_done,
                                                            i_send_accepted, i_peek_index));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                progress = 1'b1;
                limit_reg = i_cfg_data;
            end
            if (progress) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    task automatic queue_op(input logic [1:0] op, input logic [7:0] data, input logic done,
            input logic acc, input logic [AddrW-1:0] pidx, input bit pick);
        t_ring_op it;
        it.op = op;
        it.data = data;
        it.done = done;
        it.acc = acc;
        it.pidx = pidx;
        it.pick = pick;
        ring_ops_pending.push_back(it);
        queued_count++;
    endtask

    task automatic queue_push();
        queue_op(OP_PUSH, 8'($urandom), 1'($urandom), 1'($urandom), AddrW'($urandom), 1'b0);
    endtask

    task automatic queue_peek();
        queue_op(($urandom_range(1) != 0) ? OP_PEEK : OP_PEEK_ALT, 8'($urandom),
                 1'($urandom), 1'($urandom), '0, 1'b1);
    endtask

    task automatic queue_tick(input logic done, input logic acc);
        queue_op(OP_TICK, 8'($urandom), done, acc, AddrW'($urandom), 1'b0);
    endtask

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (accepted_count != queued_count || ring_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_block_limit(input logic [9:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly bursts of pushes followed by polling ticks, with some noise.
    task automatic queue_random_phase(input int unsigned count);
        int unsigned made;
        int unsigned n;
        int unsigned r;
        logic [1:0]  op;
        made = 0;
        while (made < count) begin
            r = $urandom_range(99);
            if (r < 15) begin
                repeat (4) begin
                    op = 2'($urandom_range(3));
                    queue_op(op, 8'($urandom), 1'($urandom), 1'($urandom),
                             AddrW'($urandom), op[1]);
                end
                made += 4;
            end else begin
                n = (r < 30) ? $urandom_range(64, 130) : $urandom_range(1, 40);
                repeat (n) begin
                    if ($urandom_range(9) == 0) begin
                        queue_peek();
                    end else begin
                        queue_push();
                    end
                end
                made += n;
                n = $urandom_range(1, 6);
                repeat (n) begin
                    queue_tick($urandom_range(9) < 8, $urandom_range(3) != 0);
                end
                made += n;
            end
        end
    endtask

    task automatic run_phase(input logic [9:0] limit, input int unsigned idle,
            input int unsigned count);
        wait_quiet();
        write_block_limit(limit);
        idle_pct = idle;
        queue_random_phase(count);
    endtask

    initial begin
        int unsigned r;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 0;
        queue_op(OP_PUSH, 8'h00, 1'b1, 1'b1, 11'h7FF, 1'b0);
        queue_op(OP_PEEK, 8'hFF, 1'b1, 1'b1, 11'd0, 1'b0);
        queue_op(OP_TICK, 8'hFF, 1'b0, 1'b1, 11'h7FF, 1'b0);
        queue_op(OP_PUSH, 8'hFF, 1'b0, 1'b0, 11'd0, 1'b0);
        queue_op(OP_PEEK_ALT, 8'h00, 1'b0, 1'b0, 11'd1, 1'b0);
        queue_op(OP_TICK, 8'h00, 1'b1, 1'b0, 11'd0, 1'b0);
        queue_op(OP_TICK, 8'h00, 1'b1, 1'b1, 11'd0, 1'b0);
        queue_op(OP_TICK, 8'h00, 1'b0, 1'b1, 11'd0, 1'b0);
        queue_op(OP_TICK, 8'h00, 1'b1, 1'b1, 11'd0, 1'b0);
        queue_op(OP_TICK, 8'h00, 1'b1, 1'b0, 11'd0, 1'b0);
        queue_op(OP_PUSH, 8'hA5, 1'b1, 1'b0, 11'h555, 1'b0);
        queue_op(OP_PUSH, 8'h5A, 1'b0, 1'b1, 11'h2AA, 1'b0);
        queue_op(OP_PEEK, 8'hFF, 1'b1, 1'b1, 11'd3, 1'b0);
        queue_op(OP_PEEK_ALT, 8'h00, 1'b1, 1'b0, 11'd2, 1'b0);

        // Push a long run of bytes with rare ticks, then drain it in chunks.
        wait_quiet();
        write_block_limit(10'd1023);
        idle_pct = 66;
        repeat (230) begin
            r = $urandom_range(99);
            if (r < 6) begin
                queue_peek();
            end else if (r < 10) begin
                queue_tick(1'($urandom), 1'b0);
            end else begin
                queue_push();
            end
        end
        repeat (16) begin
            queue_tick(1'b1, 1'b1);
            if ($urandom_range(3) == 0) begin
                queue_peek();
            end
        end

        run_phase(10'd0, 19, 110);
        run_phase(10'd1, 0, 110);
        run_phase(10'd64, 66, 110);
        run_phase(10'd512, 19, 110);
        run_phase(10'd100, 0, 110);
        run_phase(10'($urandom_range(1, 1023)), 66, 110);
        run_phase(10'd1023, 19, 110);

        wait_quiet();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
design/ubc_pkg.sv
design/ubc_step.sv
design/usb_bulk_in_tx_ring_chunker.sv
bench/tb_usb_bulk_in_tx_ring_chunker.sv
